// ===== src/dips_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dips_pkg: shared definitions for the dual wheel speed PID
// Widths, reset values and register indexes used across the design.
// ----------------------------------------------------------------------------
package dips_pkg;

  localparam int SPEED_WIDTH_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 12;

  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 11;
  localparam int DRIVE_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd21504;
  localparam logic [GAIN_W-1:0]  KI_RESET    = 16'd3146;
  localparam logic [GAIN_W-1:0]  KD_RESET    = 16'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd950;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_LEFT      = 3'd0,
    REG_KI_LEFT      = 3'd1,
    REG_KD_LEFT      = 3'd2,
    REG_KP_RIGHT     = 3'd3,
    REG_KI_RIGHT     = 3'd4,
    REG_KD_RIGHT     = 3'd5,
    REG_OUTPUT_LIMIT = 3'd6
  } cfg_index_t;

endpackage

// ===== src/dips_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel interfaces for the dual wheel speed PID
// Valid/ready channels for the speed input items and the drive result items.
// ----------------------------------------------------------------------------
interface dips_speed_if
  import dips_pkg::*;
#(
  parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] target_left;
  logic signed [SPEED_WIDTH-1:0] measured_left;
  logic signed [SPEED_WIDTH-1:0] target_right;
  logic signed [SPEED_WIDTH-1:0] measured_right;

  modport source (output valid, target_left, measured_left, target_right,
                  measured_right, input ready);
  modport sink   (input valid, target_left, measured_left, target_right,
                  measured_right, output ready);
endinterface

interface dips_drive_if
  import dips_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_left;
  logic signed [DRIVE_W-1:0] drive_right;

  modport source (output valid, drive_left, drive_right, input ready);
  modport sink   (input valid, drive_left, drive_right, output ready);
endinterface

// ===== src/dual_incremental_pid_speed_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_incremental_pid_speed_unit: two-wheel incremental PID speed controller
// Velocity-form PID per wheel with saturated integer drive outputs.
// ----------------------------------------------------------------------------
// The unit accepts one speed item per clock cycle unless the result stalls,
// and returns one drive item for each: the item is captured in an input
// register, then the error, delta, the three gain multiplies, the truncation
// and the saturation for both wheels settle in one pass into the result
// register, while the wheel state updates on the same edge. A stalled result
// holds the input register, so a new item is taken whenever the input register
// is empty or moving on. The user must write gains and the output limit through
// the configuration port while no item is in flight; no logic enforces it.
module dual_incremental_pid_speed_unit
  import dips_pkg::*;
#(
  parameter int SPEED_WIDTH    = SPEED_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dips_speed_if.sink            speeds,
  dips_drive_if.source          drives
);

  localparam int ERR_W = SPEED_WIDTH + 2;

  logic [GAIN_W-1:0]  kp_left, ki_left, kd_left;
  logic [GAIN_W-1:0]  kp_right, ki_right, kd_right;
  logic [LIMIT_W-1:0] output_limit;

  logic                          in_valid;
  logic signed [SPEED_WIDTH-1:0] target_left, measured_left;
  logic signed [SPEED_WIDTH-1:0] target_right, measured_right;
  logic                          out_valid;
  logic signed [DRIVE_W-1:0]     drive_left, drive_right;

  logic                      advance, take;
  logic signed [ERR_W-1:0]   error_left, error_right;
  logic signed [DRIVE_W-1:0] drive_left_next, drive_right_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_left      <= KP_RESET;
      ki_left      <= KI_RESET;
      kd_left      <= KD_RESET;
      kp_right     <= KP_RESET;
      ki_right     <= KI_RESET;
      kd_right     <= KD_RESET;
      output_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_LEFT:      kp_left      <= cfg_data[GAIN_W-1:0];
        REG_KI_LEFT:      ki_left      <= cfg_data[GAIN_W-1:0];
        REG_KD_LEFT:      kd_left      <= cfg_data[GAIN_W-1:0];
        REG_KP_RIGHT:     kp_right     <= cfg_data[GAIN_W-1:0];
        REG_KI_RIGHT:     ki_right     <= cfg_data[GAIN_W-1:0];
        REG_KD_RIGHT:     kd_right     <= cfg_data[GAIN_W-1:0];
        REG_OUTPUT_LIMIT: output_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance      = in_valid && (!out_valid || drives.ready);
  assign speeds.ready = !in_valid || advance;
  assign take         = speeds.valid && speeds.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      target_left    <= speeds.target_left;
      measured_left  <= speeds.measured_left;
      target_right   <= speeds.target_right;
      measured_right <= speeds.measured_right;
    end
  end

  // The right encoder counts the other way, so its measurement is negated.
  assign error_left  = ERR_W'(target_left) - ERR_W'(measured_left);
  assign error_right = ERR_W'(target_right) + ERR_W'(measured_right);

  dips_channel #(
    .SPEED_WIDTH    (SPEED_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_left (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .error      (error_left),
    .kp         (kp_left),
    .ki         (ki_left),
    .kd         (kd_left),
    .limit      (output_limit),
    .drive_next (drive_left_next)
  );

  dips_channel #(
    .SPEED_WIDTH    (SPEED_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_right (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .error      (error_right),
    .kp         (kp_right),
    .ki         (ki_right),
    .kd         (kd_right),
    .limit      (output_limit),
    .drive_next (drive_right_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (drives.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_left  <= drive_left_next;
      drive_right <= drive_right_next;
    end
  end

  assign drives.valid       = out_valid;
  assign drives.drive_left  = drive_left;
  assign drives.drive_right = drive_right;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_valid)
    else $error("pipeline not empty after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !drives.ready) |-> !speeds.ready)
    else $error("input taken while both stages are full and stalled");

  a_left_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_left <= $signed({1'b0, output_limit}))
                  && (drive_left >= -$signed({1'b0, output_limit})))
    else $error("left drive outside the output limit");

  a_right_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_right <= $signed({1'b0, output_limit}))
                  && (drive_right >= -$signed({1'b0, output_limit})))
    else $error("right drive outside the output limit");
`endif

endmodule

// ===== src/dips_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dips_channel: one wheel of the incremental PID
// Computes the next saturated drive from the error and updates the held state.
// ----------------------------------------------------------------------------
module dips_channel
  import dips_pkg::*;
#(
  parameter int SPEED_WIDTH    = SPEED_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic signed [SPEED_WIDTH+1:0] error,
  input  logic        [GAIN_W-1:0]      kp,
  input  logic        [GAIN_W-1:0]      ki,
  input  logic        [GAIN_W-1:0]      kd,
  input  logic        [LIMIT_W-1:0]     limit,
  output logic signed [DRIVE_W-1:0]     drive_next
);

  localparam int ERR_W   = SPEED_WIDTH + 2;
  localparam int DELTA_W = ERR_W + 1;
  localparam int DD_W    = DELTA_W + 1;
  localparam int PROD_W  = GAIN_W + 1 + DD_W;
  localparam int SUM_W   = (PROD_W + 2 > DRIVE_W + GAIN_FRAC_BITS) ?
                           PROD_W + 3 : DRIVE_W + GAIN_FRAC_BITS + 1;
  localparam int TRUNC_W = SUM_W - GAIN_FRAC_BITS;

  logic signed [ERR_W-1:0]   last_error;
  logic signed [DELTA_W-1:0] last_delta;
  logic signed [DRIVE_W-1:0] held_drive;

  logic signed [DELTA_W-1:0] delta;
  logic signed [DD_W-1:0]    delta_diff;
  logic signed [GAIN_W:0]    kp_s, ki_s, kd_s;
  logic signed [PROD_W-1:0]  p_term, i_term, d_term;
  logic signed [SUM_W-1:0]   sum, sum_adj, bias;
  logic signed [TRUNC_W-1:0] whole, lim_pos, lim_neg;

  assign kp_s = $signed({1'b0, kp});
  assign ki_s = $signed({1'b0, ki});
  assign kd_s = $signed({1'b0, kd});

  assign delta      = DELTA_W'(error) - DELTA_W'(last_error);
  assign delta_diff = DD_W'(delta) - DD_W'(last_delta);

  assign p_term = kp_s * delta;
  assign i_term = ki_s * error;
  assign d_term = kd_s * delta_diff;

  assign sum = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term)
             + (SUM_W'(held_drive) <<< GAIN_FRAC_BITS);

  // Adding the fraction mask before the arithmetic shift makes negative sums
  // round toward zero.
  assign bias    = sum[SUM_W-1] ? SUM_W'({GAIN_FRAC_BITS{1'b1}}) : '0;
  assign sum_adj = sum + bias;
  assign whole   = sum_adj[SUM_W-1:GAIN_FRAC_BITS];

  assign lim_pos = $signed(TRUNC_W'({1'b0, limit}));
  assign lim_neg = -lim_pos;

  always_comb begin
    if (whole >= lim_pos) begin
      drive_next = DRIVE_W'(lim_pos);
    end else if (whole <= lim_neg) begin
      drive_next = DRIVE_W'(lim_neg);
    end else begin
      drive_next = whole[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      last_delta <= '0;
      held_drive <= '0;
    end else if (advance) begin
      last_error <= error;
      last_delta <= delta;
      held_drive <= drive_next;
    end
  end

`ifndef ASSERT_OFF
  a_error_kept: assert property (@(posedge clk) disable iff (rst)
    advance |=> last_error == $past(error))
    else $error("previous error not captured on update");

  a_delta_kept: assert property (@(posedge clk) disable iff (rst)
    advance |=> last_delta == $past(delta))
    else $error("previous delta not captured on update");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(held_drive) && $stable(last_error))
    else $error("channel state changed without an item");
`endif

endmodule

// ===== tb/dual_incremental_pid_speed_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_incremental_pid_speed_unit_tb: self-checking bench for the wheel PID
// Drives speed items through directed corners and randomized gain/limit
// phases, predicts every drive item in the bench and compares in order.
// ----------------------------------------------------------------------------
module dual_incremental_pid_speed_unit_tb;
  import dips_pkg::*;

  localparam int SW           = SPEED_WIDTH_DEF;
  localparam int FRAC         = GAIN_FRAC_BITS_DEF;
  localparam int LEFT         = 0;
  localparam int RIGHT        = 1;
  localparam int PIPE_TAIL    = 4;
  localparam int MAX_WAIT     = 13;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 125;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [SW-1:0] SPEED_MIN  = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SPEED_MAX  = {1'b0, {(SW-1){1'b1}}};

  typedef struct packed {
    logic signed [SW-1:0] target_left;
    logic signed [SW-1:0] measured_left;
    logic signed [SW-1:0] target_right;
    logic signed [SW-1:0] measured_right;
  } speed_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_left;
    logic signed [DRIVE_W-1:0] drive_right;
  } drive_pair_t;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    speed_item_t           speeds;
    bit                    known;
    drive_pair_t           known_drives;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dips_speed_if #(.SPEED_WIDTH(SW)) speed_ch ();
  dips_drive_if drive_ch ();

  dual_incremental_pid_speed_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .speeds    (speed_ch),
    .drives    (drive_ch)
  );

  // Bench copy of the controller state and registers.
  logic [GAIN_W-1:0]  gain_p [2];
  logic [GAIN_W-1:0]  gain_i [2];
  logic [GAIN_W-1:0]  gain_d [2];
  logic [LIMIT_W-1:0] drive_limit;
  longint             prev_error [2];
  longint             prev_delta [2];
  longint             held_drive [2];

  drive_pair_t expected_drives [$];
  bit          no_gaps = 1'b0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          drives_checked = 0;
  int          settings_used = 0;
  int          cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_predictor();
    for (int s = LEFT; s <= RIGHT; s++) begin
      gain_p[s]     = KP_RESET;
      gain_i[s]     = KI_RESET;
      gain_d[s]     = KD_RESET;
      prev_error[s] = 0;
      prev_delta[s] = 0;
      held_drive[s] = 0;
    end
    drive_limit = LIMIT_RESET;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_KP_LEFT:      gain_p[LEFT]  = data[GAIN_W-1:0];
      REG_KI_LEFT:      gain_i[LEFT]  = data[GAIN_W-1:0];
      REG_KD_LEFT:      gain_d[LEFT]  = data[GAIN_W-1:0];
      REG_KP_RIGHT:     gain_p[RIGHT] = data[GAIN_W-1:0];
      REG_KI_RIGHT:     gain_i[RIGHT] = data[GAIN_W-1:0];
      REG_KD_RIGHT:     gain_d[RIGHT] = data[GAIN_W-1:0];
      REG_OUTPUT_LIMIT: drive_limit   = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // One velocity-form update; the accumulated value keeps FRAC fraction bits.
  function automatic logic signed [DRIVE_W-1:0] wheel_drive(input int side,
                                                            input longint target,
                                                            input longint measured);
    longint err, dlt, inc, acc, drv, lim;
    lim = longint'(drive_limit);
    err = target - measured;
    dlt = err - prev_error[side];
    inc = longint'(gain_p[side]) * dlt + longint'(gain_i[side]) * err
        + longint'(gain_d[side]) * (dlt - prev_delta[side]);
    acc = held_drive[side] * (longint'(1) << FRAC) + inc;
    // Truncation goes toward zero on both sides.
    if (acc >= 0) drv = acc >>> FRAC;
    else          drv = -((-acc) >>> FRAC);
    if (drv >= lim)       drv = lim;
    else if (drv <= -lim) drv = -lim;
    prev_delta[side] = dlt;
    prev_error[side] = err;
    held_drive[side] = drv;
    return drv[DRIVE_W-1:0];
  endfunction

  function automatic drive_pair_t predict_drives(input speed_item_t s);
    drive_pair_t d;
    d.drive_left  = wheel_drive(LEFT, longint'(s.target_left), longint'(s.measured_left));
    d.drive_right = wheel_drive(RIGHT, longint'(s.target_right),
                                -longint'(s.measured_right));
    return d;
  endfunction

  function automatic directed_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_DATA_W-1:0] data);
    directed_row_t r;
    r          = '{default: '0};
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic directed_row_t row_item(input int tl, input int ml,
                                             input int tr, input int mr);
    directed_row_t r;
    r        = '{default: '0};
    r.speeds = '{target_left: tl[SW-1:0], measured_left: ml[SW-1:0],
                 target_right: tr[SW-1:0], measured_right: mr[SW-1:0]};
    return r;
  endfunction

  function automatic directed_row_t row_known(input int tl, input int ml, input int tr,
                                              input int mr, input int dl, input int dr);
    directed_row_t r;
    r              = row_item(tl, ml, tr, mr);
    r.known        = 1'b1;
    r.known_drives = '{drive_left: dl[DRIVE_W-1:0], drive_right: dr[DRIVE_W-1:0]};
    return r;
  endfunction

  function automatic logic signed [SW-1:0] corner_speed();
    case ($urandom_range(0, 4))
      0:       return SPEED_MIN;
      1:       return SPEED_MAX;
      2:       return '0;
      3:       return '1;
      default: return SW'(1);
    endcase
  endfunction

  // Mostly a tracking wheel with small noise; the rest is full-range noise
  // and corner values.
  function automatic speed_item_t random_speeds();
    speed_item_t s;
    int          tl, tr, kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      tl = int'($urandom_range(0, 600)) - 300;
      tr = int'($urandom_range(0, 600)) - 300;
      s.target_left    = SW'(tl);
      s.measured_left  = SW'(tl + int'($urandom_range(0, 60)) - 30);
      s.target_right   = SW'(tr);
      // The right encoder counts backwards.
      s.measured_right = SW'(-(tr + int'($urandom_range(0, 60)) - 30));
    end else if (kind <= 7) begin
      s = {$urandom, $urandom};
    end else begin
      s.target_left    = corner_speed();
      s.measured_left  = corner_speed();
      s.target_right   = corner_speed();
      s.measured_right = corner_speed();
    end
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain(input int phase);
    if (phase == 1) return '1;
    if (phase == 2) return '0;
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return CFG_DATA_W'($urandom_range(0, 16'h1FFF));
      default:    return CFG_DATA_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit(input int phase);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
    if (phase == 1) return '1;
    if (phase == 3 || $urandom_range(0, 7) == 0) begin
      v[LIMIT_W-1:0] = '0;
      return v;
    end
    if ($urandom_range(0, 7) == 0) v[LIMIT_W-1:0] = '1;
    return v;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_register(idx, data);
    @(posedge clk);
  endtask

  // Hold the sender until every drive item has come back, then let the
  // pipeline settle before any register is touched.
  task automatic settle_pipeline();
    speed_ch.valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (PIPE_TAIL) @(posedge clk);
  endtask

  task automatic send_speeds(input speed_item_t s, input bit known,
                             input drive_pair_t typed);
    int          gap;
    drive_pair_t want;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      speed_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    speed_ch.valid          <= 1'b1;
    speed_ch.target_left    <= s.target_left;
    speed_ch.measured_left  <= s.measured_left;
    speed_ch.target_right   <= s.target_right;
    speed_ch.measured_right <= s.measured_right;
    do @(posedge clk); while (!speed_ch.ready);
    want = predict_drives(s);
    expected_drives.push_back(known ? typed : want);
    items_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d drive items outstanding",
               cycle_count, expected_drives.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : drive_monitor
    int          stall;
    drive_pair_t want;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        drive_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      drive_ch.ready <= 1'b1;
      do @(posedge clk); while (!drive_ch.valid);
      if (expected_drives.size() == 0) begin
        $error("drive item with no expectation: drive_left %0d, drive_right %0d",
               drive_ch.drive_left, drive_ch.drive_right);
        mismatches++;
      end else begin
        want = expected_drives.pop_front();
        if (drive_ch.drive_left !== want.drive_left) begin
          $error("drive_left mismatch: expected %0d, actual %0d",
                 want.drive_left, drive_ch.drive_left);
          mismatches++;
        end
        if (drive_ch.drive_right !== want.drive_right) begin
          $error("drive_right mismatch: expected %0d, actual %0d",
                 want.drive_right, drive_ch.drive_right);
          mismatches++;
        end
        drives_checked++;
      end
    end
  end

  initial begin : stimulus
    directed_row_t plan [$];
    bit            cfg_open;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    speed_ch.valid          = 1'b0;
    speed_ch.target_left    = '0;
    speed_ch.measured_left  = '0;
    speed_ch.target_right   = '0;
    speed_ch.measured_right = '0;
    drive_ch.ready          = 1'b0;
    cfg_open                = 1'b0;
    reset_predictor();

    // Reset gains first: zero item, then full-scale error both ways.
    plan.push_back(row_known(0, 0, 0, 0, 0, 0));
    plan.push_back(row_known(32767, -32768, 32767, 32767, 950, 950));
    plan.push_back(row_known(-32768, 32767, -32768, -32768, -950, -950));
    plan.push_back(row_item(120, 100, -40, 25));
    plan.push_back(row_item(-7, 3, 9, -9));
    // Limit value with only upper bits set lands on a zero limit.
    plan.push_back(row_write(REG_OUTPUT_LIMIT, 16'hF800));
    plan.push_back(row_known(32767, -32768, 32767, 32767, 0, 0));
    plan.push_back(row_known(0, 0, 0, 0, 0, 0));
    // Half proportional gain only, so the truncation direction is visible.
    plan.push_back(row_write(REG_KP_LEFT, 16'h0800));
    plan.push_back(row_write(REG_KI_LEFT, 16'h0000));
    plan.push_back(row_write(REG_KD_LEFT, 16'h0000));
    plan.push_back(row_write(REG_KP_RIGHT, 16'h0800));
    plan.push_back(row_write(REG_KI_RIGHT, 16'h0000));
    plan.push_back(row_write(REG_KD_RIGHT, 16'h0000));
    plan.push_back(row_write(REG_OUTPUT_LIMIT, 16'hFFFF));
    plan.push_back(row_write(REG_UNUSED, 16'hFFFF));
    plan.push_back(row_known(0, 1, 0, -1, 0, 0));
    plan.push_back(row_known(0, 3, 0, -3, -1, -1));
    plan.push_back(row_known(0, 0, 0, 0, 0, 0));
    plan.push_back(row_write(REG_KD_LEFT, 16'hFFFF));
    plan.push_back(row_write(REG_KD_RIGHT, 16'hFFFF));
    plan.push_back(row_write(REG_KP_LEFT, 16'hFFFF));
    plan.push_back(row_write(REG_KI_RIGHT, 16'hFFFF));
    plan.push_back(row_item(500, -500, -300, -200));
    plan.push_back(row_item(-32768, 32767, 32767, -32768));
    plan.push_back(row_item(17, 17, -17, 17));
    plan.push_back(row_item(32767, 32767, -32768, 32767));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    settings_used = 1;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!cfg_open) begin
          settle_pipeline();
          settings_used++;
        end
        cfg_write(plan[i].reg_idx, plan[i].reg_data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_we <= 1'b0;
        cfg_open = 1'b0;
        send_speeds(plan[i].speeds, plan[i].known, plan[i].known_drives);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      // Every phase starts from an empty pipeline.
      settle_pipeline();
      cfg_write(REG_KP_LEFT, pick_gain(p));
      cfg_write(REG_KI_LEFT, pick_gain(p));
      cfg_write(REG_KD_LEFT, pick_gain(p));
      cfg_write(REG_KP_RIGHT, pick_gain(p));
      cfg_write(REG_KI_RIGHT, pick_gain(p));
      cfg_write(REG_KD_RIGHT, pick_gain(p));
      cfg_write(REG_OUTPUT_LIMIT, pick_limit(p));
      if ($urandom_range(0, 1) == 1) begin
        cfg_write(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
      end
      cfg_we <= 1'b0;
      settings_used++;
      no_gaps = (p % 3 == 2);
      repeat (PHASE_ITEMS) send_speeds(random_speeds(), 1'b0, '0);
    end

    no_gaps = 1'b0;
    settle_pipeline();

    $display("Ran %0d speed items under %0d register settings; %0d drive items compared.",
             items_sent, settings_used, drives_checked);
    $display("Gain and limit extremes, zero limit, truncation and saturation were exercised.");
    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== dual_incremental_pid_speed_unit.f =====
src/dips_pkg.sv
src/dips_if.sv
src/dips_channel.sv
src/dual_incremental_pid_speed_unit.sv
tb/dual_incremental_pid_speed_unit_tb.sv
